FILE: design/gssc_pkg.sv
// Shared types, widths and constant tables of the grid-search steering controller.
package gssc_pkg;

   // Fixed widths of the beat fields.
   localparam int ANGLE_W = 16;           // heading and target, Q3.12
   localparam int SPEED_W = 16;           // speed, Q7.8
   localparam int TSTEP_W = 16;           // time step, Q0.16
   localparam int ACCEL_W = 6;            // acceleration in tenths
   localparam int IDX_W   = 4;            // steering grid index
   localparam int STEER_W = 15;           // steering angle, Q0.14

   // Datapath widths.
   localparam int DTH_W   = ANGLE_W + 1;  // target minus heading
   localparam int VDT_W   = SPEED_W + TSTEP_W + 1;
   localparam int MULB_W  = TSTEP_W + 1;
   localparam int PROD_W  = VDT_W + MULB_W;
   localparam int PRED_SHIFT = 26;
   localparam int RND_W   = PROD_W - PRED_SHIFT;
   localparam int ERR_W   = 21;           // |error| stays below 2^21
   localparam int COST_W  = 30;
   localparam int ACOST_W = 17;           // 10 * |steering angle|

   localparam int STEER_LIMIT = 16;       // steering entries inside +-pi/4
   localparam int ACCEL_LIMIT = 41;       // acceleration entries inside +-2.0
   localparam int ACCEL_ZERO  = 20;       // index of zero acceleration
   localparam int ERR_WEIGHT  = 200;

   localparam int DEFAULT_STEER_STEPS = 16;
   localparam int DEFAULT_ACCEL_STEPS = 41;

   localparam logic [TSTEP_W-1:0] TIME_STEP_RESET = 16'd655;

   typedef logic signed [15:0]        tan_entry_type;
   typedef logic signed [STEER_W-1:0] angle_entry_type;
   typedef logic [ACOST_W-1:0]        acost_entry_type;

   // tan(-pi/4 + 0.1 j) in Q1.14.
   localparam tan_entry_type TAN_TABLE [STEER_LIMIT] = '{
      -16'sd16384, -16'sd13396, -16'sd10861, -16'sd8642,
      -16'sd6647,  -16'sd4807,  -16'sd3073,  -16'sd1403,
       16'sd239,    16'sd1886,   16'sd3571,   16'sd5332,
       16'sd7211,   16'sd9264,   16'sd11564,  16'sd14214
   };

   // Steering angle -pi/4 + 0.1 j in Q0.14.
   localparam angle_entry_type ANGLE_TABLE [STEER_LIMIT] = '{
      -15'sd12868, -15'sd11230, -15'sd9591, -15'sd7953,
      -15'sd6314,  -15'sd4676,  -15'sd3038, -15'sd1399,
       15'sd239,    15'sd1878,   15'sd3516,  15'sd5154,
       15'sd6793,   15'sd8431,   15'sd10070, 15'sd11708
   };

   // Steering effort cost, 10 * |angle|.
   localparam acost_entry_type ACOST_TABLE [STEER_LIMIT] = '{
      17'd128680, 17'd112300, 17'd95910, 17'd79530,
      17'd63140,  17'd46760,  17'd30380, 17'd13990,
      17'd2390,   17'd18780,  17'd35160, 17'd51540,
      17'd67930,  17'd84310,  17'd100700, 17'd117080
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCALE,
      ST_LOAD,
      ST_SEARCH,
      ST_DRAIN,
      ST_RESULT
   } gssc_state_type;

   // Work handed to the cost unit.
   typedef struct packed {
      logic             valid;   // evaluate steering candidate idx
      logic             scale;   // form speed * time_step instead
      logic             last;
      logic [IDX_W-1:0] idx;
   } gssc_issue_type;

   // Cost of one steering candidate leaving the cost unit.
   typedef struct packed {
      logic              valid;
      logic              last;
      logic [IDX_W-1:0]  idx;
      logic [COST_W-1:0] cost;
   } gssc_result_type;

endpackage

FILE: design/gssc_cost_unit.sv
// Shared multiplier and candidate cost pipeline of the grid-search steering controller.
module gssc_cost_unit import gssc_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  gssc_issue_type            issue,
   input  logic signed [SPEED_W-1:0] speed,
   input  logic [TSTEP_W-1:0]        time_step,
   input  logic signed [DTH_W-1:0]   dtheta,
   output gssc_result_type           result
);

   logic signed [VDT_W-1:0]  mul_a;
   logic signed [MULB_W-1:0] mul_b;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [VDT_W-1:0]  vdt_ff;
   gssc_issue_type           s1_ff;
   gssc_issue_type           s2_ff;

   logic signed [PROD_W-1:0] rnd_sum;
   logic signed [RND_W-1:0]  rnd;
   logic signed [RND_W:0]    err;
   logic [RND_W:0]           err_abs;
   logic [ERR_W-1:0]         err_in;
   logic [ERR_W-1:0]         err_ff;
   logic [COST_W-1:0]        cost_in;
   gssc_result_type          result_ff;

   // One multiplier serves both the speed scaling and every candidate.
   always_comb begin
      if (issue.scale) begin
         mul_a = VDT_W'(speed);
         mul_b = $signed({1'b0, time_step});
      end else begin
         mul_a = vdt_ff;
         mul_b = MULB_W'(TAN_TABLE[issue.idx]);
      end
      prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);
   end

   // Round half away from zero: floor((p + half - sign) / 2^shift).
   always_comb begin
      rnd_sum = prod_ff + (PROD_W'(1) <<< (PRED_SHIFT - 1))
                - PROD_W'(prod_ff[PROD_W-1]);
      rnd     = rnd_sum[PROD_W-1:PRED_SHIFT];
      err     = (RND_W+1)'(dtheta) - (RND_W+1)'(rnd);
      err_abs = err[RND_W] ? (RND_W+1)'(-err) : (RND_W+1)'(err);
      err_in  = err_abs[ERR_W-1:0];
      cost_in = COST_W'(err_ff) * COST_W'(ERR_WEIGHT) + COST_W'(ACOST_TABLE[s2_ff.idx]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff           <= '0;
         s2_ff           <= '0;
         result_ff.valid <= 1'b0;
      end else begin
         s1_ff           <= issue;
         s2_ff           <= s1_ff;
         result_ff.valid <= s2_ff.valid;
      end
      prod_ff        <= prod_in;
      err_ff         <= err_in;
      result_ff.last <= s2_ff.last;
      result_ff.idx  <= s2_ff.idx;
      result_ff.cost <= cost_in;
      if (s1_ff.scale) begin
         vdt_ff <= prod_ff[VDT_W-1:0];
      end
   end

   assign result = result_ff;

endmodule

FILE: design/grid_search_steering_controller.sv
// Top level of the grid-search steering controller.
//
// The controller takes a beat with the current heading, speed and target heading and returns
// one beat with the cheapest control on a grid of accelerations and steering angles. The
// predicted heading is heading + speed * time_step * tan(steer), and the cost is
// 0.5 * |target - predicted| + 0.1 * (|accel| + |steer|), exact in fixed point; ties keep the
// earlier candidate in search order (accelerations outer, steering inner). Because the
// acceleration term does not depend on the steering choice, the winning acceleration is the
// legal grid entry nearest zero and is fixed for a given ACCEL_STEPS; only the steering
// candidates are scored. One shared multiplier first forms speed * time_step and then scores
// one steering candidate per cycle through a three-stage cost pipeline. After a request beat
// is accepted, the sequencer passes through a scale state that forms the speed product, a
// load state that registers it, a search state that issues the steering candidates and a
// drain state that waits for the last cost to leave the pipeline; it then raises rsp_tvalid
// and holds the response beat until rsp_tready is high. The block takes one beat at a time:
// req_tready is high only while the sequencer is idle, and the sequencer returns to idle
// only after a response beat. The time_step register (unsigned Q0.16, reset value 655) is
// written through csr_wen and csr_wdata and should only be changed while the block is idle.
module grid_search_steering_controller import gssc_pkg::*; #(
   parameter int STEER_STEPS = DEFAULT_STEER_STEPS,
   parameter int ACCEL_STEPS = DEFAULT_ACCEL_STEPS
) (
   input  logic         clock,
   input  logic         reset,
   // Request channel.
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [47:0]  req_tdata,   // heading [15:0], speed [31:16], target_heading [47:32]
   // Response channel.
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata,   // accel_tenths [5:0], steering_index [9:6],
                                     // steer_angle [24:10], zero [31:25]
   // Time step register.
   input  logic         csr_wen,
   input  logic [15:0]  csr_wdata
);

   // Both grids are clamped to their limits; only steering entries are scored.
   localparam int SEARCH_LEN = (STEER_STEPS < STEER_LIMIT) ? STEER_STEPS : STEER_LIMIT;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SEARCH_LEN - 1);
   localparam int ACCEL_TOP  = (ACCEL_STEPS < ACCEL_LIMIT) ? ACCEL_STEPS : ACCEL_LIMIT;
   // The legal acceleration index nearest zero acceleration.
   localparam int BEST_ACCEL_IDX = (ACCEL_TOP - 1 < ACCEL_ZERO) ? ACCEL_TOP - 1 : ACCEL_ZERO;
   localparam logic [ACCEL_W-1:0] BEST_ACCEL = ACCEL_W'(BEST_ACCEL_IDX - ACCEL_ZERO);

   gssc_state_type            state_ff;
   gssc_state_type            state_in;
   logic [TSTEP_W-1:0]        time_step_ff;
   logic signed [SPEED_W-1:0] speed_ff;
   logic signed [DTH_W-1:0]   dtheta_ff;
   logic signed [DTH_W-1:0]   dtheta_in;
   logic [IDX_W-1:0]          idx_ff;
   logic [IDX_W-1:0]          best_idx_ff;
   logic [COST_W-1:0]         best_cost_ff;
   logic                      take_best;
   logic                      req_beat;
   gssc_issue_type            issue;
   gssc_result_type           result;

   assign req_beat  = req_tvalid && req_tready;
   assign dtheta_in = DTH_W'($signed(req_tdata[47:32])) - DTH_W'($signed(req_tdata[15:0]));

   // The time step register is written whenever the write enable is high.
   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff <= TIME_STEP_RESET;
      end else if (csr_wen) begin
         time_step_ff <= csr_wdata;
      end
   end

   // Next-state logic of the sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE:  state_in = ST_LOAD;
         ST_LOAD:   state_in = ST_SEARCH;
         ST_SEARCH: begin
            if (idx_ff == LAST_IDX) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (result.valid && result.last) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // Output logic of the sequencer.
   always_comb begin
      req_tready  = 1'b0;
      rsp_tvalid  = 1'b0;
      issue       = '0;
      issue.idx   = idx_ff;
      unique case (state_ff)
         ST_IDLE:   req_tready  = 1'b1;
         ST_SCALE:  issue.scale = 1'b1;
         ST_SEARCH: begin
            issue.valid = 1'b1;
            issue.last  = (idx_ff == LAST_IDX);
         end
         ST_RESULT: rsp_tvalid  = 1'b1;
         default:   issue       = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_SEARCH) begin
            idx_ff <= idx_ff + IDX_W'(1);
         end else begin
            idx_ff <= '0;
         end
      end
   end

   // Operands are captured with the request beat.
   always_ff @(posedge clock) begin
      if (req_beat) begin
         speed_ff  <= $signed(req_tdata[31:16]);
         dtheta_ff <= dtheta_in;
      end
   end

   // Running minimum; the first candidate always loads, later ones only on a strictly lower
   // cost, so equal costs keep the earlier steering index.
   assign take_best = result.valid && ((result.idx == '0) || (result.cost < best_cost_ff));

   always_ff @(posedge clock) begin
      if (take_best) begin
         best_cost_ff <= result.cost;
         best_idx_ff  <= result.idx;
      end
   end

   gssc_cost_unit u_cost (
      .clock     (clock),
      .reset     (reset),
      .issue     (issue),
      .speed     (speed_ff),
      .time_step (time_step_ff),
      .dtheta    (dtheta_ff),
      .result    (result)
   );

   assign rsp_tdata = {7'd0, ANGLE_TABLE[best_idx_ff], best_idx_ff, BEST_ACCEL};

   // The block never takes a request while a result is waiting.
   assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request taken while a result is pending");

   // Candidate costs only come back while the search is running or draining.
   assert property (@(posedge clock) disable iff (reset)
      result.valid |-> (state_ff == ST_SEARCH || state_ff == ST_DRAIN))
      else $error("candidate cost outside the search");

   // A delivered result frees the block for the next request.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready) |=> req_tready)
      else $error("block not idle after result beat");

   // The chosen steering index lies inside the searched part of the grid.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (best_idx_ff <= LAST_IDX))
      else $error("steering index outside the search range");

   // The last candidate is issued exactly when the search leaves for the drain.
   assert property (@(posedge clock) disable iff (reset)
      (issue.valid && issue.last) |=> (state_ff == ST_DRAIN))
      else $error("search did not end after its last candidate");

endmodule
